@@ sv/ssym_pkg.sv @@
package ssym_pkg;

   // Store geometry
   localparam int ENTRIES   = 256;
   localparam int MAX_SCOPE = 255;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int LVL_W     = $clog2(MAX_SCOPE + 1);
   localparam int KEY_W     = 48;

   typedef enum logic [1:0] {
      ACT_OPEN    = 2'd0,
      ACT_CLOSE   = 2'd1,
      ACT_LOOKUP  = 2'd2,
      ACT_DECLARE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_FOUND      = 2'd0,
      STAT_UNDECLARED = 2'd1,
      STAT_MULTIPLE   = 2'd2,
      STAT_FULL       = 2'd3
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [KEY_W-1:0]   name_key;
      logic [KEY_W-1:0]   type_key;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [KEY_W-1:0]   type_out;
   } rsp_type;

   // One stored symbol
   typedef struct packed {
      logic [KEY_W-1:0]   name_key;
      logic [KEY_W-1:0]   type_key;
      logic [LVL_W-1:0]   scope;
   } entry_rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_TAIL,
      S_DONE,
      S_REPORT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic       latch_cmd;
      logic       level_inc;
      logic       level_dec;
      logic       scan_start;
      logic       rd_en;
      logic       set_res;
      status_type res_code;
      logic       set_halt;
      logic       commit;
      logic       load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type action;
      logic       halted;
      logic       level_max;
      logic       scan_last;
      logic       dup;
      logic       found;
      logic       have_free;
      logic       out_free;
   } stat_type;

endpackage

@@ sv/ssym_ram.sv @@
module ssym_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ssym_ctrl.sv @@
module ssym_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssym_pkg::stat_type  stat_i,
   output ssym_pkg::cmd_type   cmd_o
);

   ssym_pkg::ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssym_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd_o          = '0;
      cmd_o.res_code = ssym_pkg::STAT_FOUND;
      case (state_ff)
         ssym_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.latch_cmd = 1'b1;
               state_in        = ssym_pkg::S_DECODE;
            end
         end
         ssym_pkg::S_DECODE: begin
            if (stat_i.halted) begin
               state_in = ssym_pkg::S_IDLE;
            end else if (stat_i.action == ssym_pkg::ACT_OPEN) begin
               if (stat_i.level_max) begin
                  cmd_o.set_res  = 1'b1;
                  cmd_o.res_code = ssym_pkg::STAT_FULL;
                  state_in       = ssym_pkg::S_REPORT;
               end else begin
                  cmd_o.level_inc = 1'b1;
                  state_in        = ssym_pkg::S_IDLE;
               end
            end else begin
               cmd_o.scan_start = 1'b1;
               state_in         = ssym_pkg::S_SCAN;
            end
         end
         ssym_pkg::S_SCAN: begin
            cmd_o.rd_en = 1'b1;
            if (stat_i.scan_last) begin
               state_in = ssym_pkg::S_TAIL;
            end
         end
         ssym_pkg::S_TAIL: begin
            // The last read word is compared in this cycle.
            state_in = ssym_pkg::S_DONE;
         end
         ssym_pkg::S_DONE: begin
            case (stat_i.action)
               ssym_pkg::ACT_CLOSE: begin
                  cmd_o.level_dec = 1'b1;
                  state_in        = ssym_pkg::S_IDLE;
               end
               ssym_pkg::ACT_LOOKUP: begin
                  cmd_o.set_res  = 1'b1;
                  cmd_o.res_code = stat_i.found ? ssym_pkg::STAT_FOUND
                                                : ssym_pkg::STAT_UNDECLARED;
                  state_in       = ssym_pkg::S_REPORT;
               end
               ssym_pkg::ACT_DECLARE: begin
                  if (stat_i.dup) begin
                     cmd_o.set_halt = 1'b1;
                     cmd_o.set_res  = 1'b1;
                     cmd_o.res_code = ssym_pkg::STAT_MULTIPLE;
                     state_in       = ssym_pkg::S_REPORT;
                  end else if (!stat_i.have_free) begin
                     cmd_o.set_res  = 1'b1;
                     cmd_o.res_code = ssym_pkg::STAT_FULL;
                     state_in       = ssym_pkg::S_REPORT;
                  end else begin
                     cmd_o.commit = 1'b1;
                     state_in     = ssym_pkg::S_IDLE;
                  end
               end
               default: begin
                  state_in = ssym_pkg::S_IDLE;
               end
            endcase
         end
         ssym_pkg::S_REPORT: begin
            if (stat_i.out_free) begin
               cmd_o.load_rsp = 1'b1;
               state_in       = ssym_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssym_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/ssym_dpath.sv @@
module ssym_dpath (
   input  logic               clock,
   input  logic               reset,
   input  ssym_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ssym_pkg::rsp_type  rsp_data,
   input  ssym_pkg::cmd_type  cmd_i,
   output ssym_pkg::stat_type stat_o
);

   localparam int EntW = $bits(ssym_pkg::entry_rec_type);

   // Latched command
   ssym_pkg::req_type               cmd_ff, cmd_in;

   // Architectural state
   logic [ssym_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [ssym_pkg::LVL_W-1:0]      level_ff, level_in;
   logic                            halted_ff, halted_in;

   // Scan pipeline
   logic [ssym_pkg::IDX_W-1:0]      cnt_ff, cnt_in;
   logic                            proc_vld_ff, proc_vld_in;
   logic [ssym_pkg::IDX_W-1:0]      proc_idx_ff, proc_idx_in;

   // Scan accumulators
   logic                            hit_ff, hit_in;
   logic [ssym_pkg::LVL_W-1:0]      best_scope_ff, best_scope_in;
   logic [ssym_pkg::KEY_W-1:0]      best_type_ff, best_type_in;
   logic                            dup_ff, dup_in;
   logic                            have_free_ff, have_free_in;
   logic [ssym_pkg::IDX_W-1:0]      free_slot_ff, free_slot_in;

   // Pending result and output register
   ssym_pkg::rsp_type               res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ssym_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   // Store access
   ssym_pkg::entry_rec_type         ent;
   ssym_pkg::entry_rec_type         wr_ent;
   logic [EntW-1:0]                 rd_word;
   logic                            ent_vld;
   logic                            name_eq;
   logic                            scope_eq;
   logic                            out_free;

   assign wr_ent.name_key = cmd_ff.name_key;
   assign wr_ent.type_key = cmd_ff.type_key;
   assign wr_ent.scope    = level_ff;

   ssym_ram #(
      .WIDTH (EntW),
      .DEPTH (ssym_pkg::ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd_i.commit),
      .wr_addr (free_slot_ff),
      .wr_data (wr_ent),
      .rd_addr (cnt_ff),
      .rd_data (rd_word)
   );

   assign ent      = ssym_pkg::entry_rec_type'(rd_word);
   assign ent_vld  = valid_ff[proc_idx_ff];
   assign name_eq  = (ent.name_key == cmd_ff.name_key);
   assign scope_eq = (ent.scope == level_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Command latch, scope level and halt flag.
   always_comb begin
      cmd_in    = cmd_i.latch_cmd ? req_data : cmd_ff;
      level_in  = level_ff;
      halted_in = halted_ff || cmd_i.set_halt;
      if (cmd_i.level_inc) begin
         level_in = level_ff + 1'b1;
      end else if (cmd_i.level_dec && (level_ff != '0)) begin
         level_in = level_ff - 1'b1;
      end
   end

   // Read address counter and compare stage.
   always_comb begin
      cnt_in      = cnt_ff;
      proc_vld_in = cmd_i.rd_en;
      proc_idx_in = cnt_ff;
      if (cmd_i.scan_start) begin
         cnt_in = '0;
      end else if (cmd_i.rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Per-entry work of the scan, and the commit of a new symbol.
   always_comb begin
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      best_scope_in = best_scope_ff;
      best_type_in  = best_type_ff;
      dup_in        = dup_ff;
      have_free_in  = have_free_ff;
      free_slot_in  = free_slot_ff;
      if (cmd_i.scan_start) begin
         hit_in        = 1'b0;
         best_scope_in = '0;
         best_type_in  = '0;
         dup_in        = 1'b0;
         have_free_in  = 1'b0;
         free_slot_in  = '0;
      end else if (proc_vld_ff) begin
         case (cmd_ff.action)
            ssym_pkg::ACT_CLOSE: begin
               if (ent_vld && scope_eq) begin
                  valid_in[proc_idx_ff] = 1'b0;
               end
            end
            ssym_pkg::ACT_LOOKUP: begin
               // Deepest visible scope wins; the first of equals is kept.
               if (ent_vld && name_eq && (ent.scope <= level_ff) &&
                   (!hit_ff || (ent.scope > best_scope_ff))) begin
                  hit_in        = 1'b1;
                  best_scope_in = ent.scope;
                  best_type_in  = ent.type_key;
               end
            end
            ssym_pkg::ACT_DECLARE: begin
               if (ent_vld) begin
                  if (name_eq && scope_eq) begin
                     dup_in = 1'b1;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_slot_in = proc_idx_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd_i.commit) begin
         valid_in[free_slot_ff] = 1'b1;
      end
   end

   // Result and output register.
   always_comb begin
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd_i.set_res) begin
         res_in.status   = cmd_i.res_code;
         res_in.type_out = (cmd_i.res_code == ssym_pkg::STAT_FOUND) ? best_type_ff : '0;
      end
      if (cmd_i.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         level_ff     <= '0;
         halted_ff    <= 1'b0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         level_ff     <= level_in;
         halted_ff    <= halted_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cnt_ff        <= cnt_in;
      proc_idx_ff   <= proc_idx_in;
      hit_ff        <= hit_in;
      best_scope_ff <= best_scope_in;
      best_type_ff  <= best_type_in;
      dup_ff        <= dup_in;
      have_free_ff  <= have_free_in;
      free_slot_ff  <= free_slot_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat_o.action    = cmd_ff.action;
   assign stat_o.halted    = halted_ff;
   assign stat_o.level_max = (level_ff == ssym_pkg::LVL_W'(ssym_pkg::MAX_SCOPE));
   assign stat_o.scan_last = (cnt_ff == ssym_pkg::IDX_W'(ssym_pkg::ENTRIES - 1));
   assign stat_o.dup       = dup_ff;
   assign stat_o.found     = hit_ff;
   assign stat_o.have_free = have_free_ff;
   assign stat_o.out_free  = out_free;

   // A result is only loaded when the output register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.load_rsp |-> out_free)
      else $error("result loaded over an untaken transaction");

   // A symbol is only stored into a free slot, never over a duplicate.
   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd_i.commit |-> (have_free_ff && !dup_ff && !valid_ff[free_slot_ff]))
      else $error("declare committed without a free slot");

   // Once halted, the block stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped");

   // The scope level never rises past its limit.
   a_level_inc: assert property (@(posedge clock) disable iff (reset)
      cmd_i.level_inc |-> !stat_o.level_max)
      else $error("scope level raised past its limit");

endmodule

@@ sv/scoped_symbol_table.sv @@
// Channel   Ports                               Moves
// request   req_valid, req_ready, req_data      one command (open, close, look up, declare)
// response  rsp_valid, rsp_ready, rsp_data      status and type, at most one per command
//
// Open scope is handled in the decode state; close, look up and declare, unless halted,
// also scan the symbol RAM one entry per cycle.
// A response passes through the report state, which waits for the output register.
// Reset is synchronous and clears valid bits, scope level and halt flag at once.
// A stalled response holds the block before it takes the next command.
module scoped_symbol_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssym_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ssym_pkg::rsp_type rsp_data
);

   ssym_pkg::cmd_type  cmd;
   ssym_pkg::stat_type stat;

   ssym_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   ssym_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd_i     (cmd),
      .stat_o    (stat)
   );

endmodule
